/* src/tlhm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_pkg
// shared types, status codes, weights and limits of the health monitor
// ----------------------------------------------------------------------------
package tlhm_pkg;

  localparam int MAX_READINGS_DEF = 256;

  // classified-word queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  // penalty weights per status
  localparam int W_WARN    = 8;
  localparam int W_AGING   = 5;
  localparam int W_CRIT    = 25;
  localparam int W_STALE   = 20;
  localparam int W_MISSING = 25;
  localparam int W_BADTIME = 20;
  localparam int W_CONFIG  = 25;

  localparam int SCORE_FULL     = 100;
  localparam int BAND_GREEN_MIN = 90;
  localparam int BAND_AMBER_MIN = 70;

  // tenths rounding: floor((2000*n + t) / (2*t))
  localparam int TENTHS_SCALE = 2000;
  localparam int TENTHS_W     = 11;
  localparam int QUOT_W       = 10;
  localparam int PEN_W        = 14;
  localparam int CLIP_W       = 7;

  typedef enum logic [2:0] {
    ST_NOMINAL  = 3'd0,
    ST_WARNING  = 3'd1,
    ST_CRITICAL = 3'd2,
    ST_AGING    = 3'd3,
    ST_STALE    = 3'd4,
    ST_MISSING  = 3'd5,
    ST_BADTIME  = 3'd6,
    ST_CONFIG   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    BAND_GREEN = 2'd0,
    BAND_AMBER = 2'd1,
    BAND_RED   = 2'd2
  } band_t;

  typedef enum logic [1:0] {
    DISP_GO      = 2'd0,
    DISP_MONITOR = 2'd1,
    DISP_HOLD    = 2'd2
  } disp_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_LOAD,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [7:0] channel;
    status_t    status;
    logic       batch_last;
  } item_t;

  function automatic logic [2:0] rank_of(input status_t st);
    logic [2:0] r;
    unique case (st)
      ST_NOMINAL:  r = 3'd0;
      ST_WARNING:  r = 3'd2;
      ST_CRITICAL: r = 3'd5;
      ST_AGING:    r = 3'd1;
      ST_STALE:    r = 3'd4;
      ST_MISSING:  r = 3'd6;
      ST_BADTIME:  r = 3'd3;
      ST_CONFIG:   r = 3'd7;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/tlhm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_in_if
// reading channel: valid/ready handshake and reading payload
// ----------------------------------------------------------------------------
interface tlhm_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         channel_id;
  logic signed [31:0] sample_value;
  logic               value_present;
  logic signed [31:0] warn_low;
  logic signed [31:0] warn_high;
  logic signed [31:0] crit_low;
  logic signed [31:0] crit_high;
  logic signed [31:0] sample_age;
  logic               age_present;
  logic signed [31:0] aging_limit;
  logic signed [31:0] stale_limit;
  logic               batch_end;

  modport source (
    output valid, channel_id, sample_value, value_present, warn_low, warn_high,
           crit_low, crit_high, sample_age, age_present, aging_limit,
           stale_limit, batch_end,
    input  ready
  );

  modport sink (
    input  valid, channel_id, sample_value, value_present, warn_low, warn_high,
           crit_low, crit_high, sample_age, age_present, aging_limit,
           stale_limit, batch_end,
    output ready
  );
endinterface

/* src/tlhm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_out_if
// result channel: valid/ready handshake, per-reading status and batch summary
// ----------------------------------------------------------------------------
interface tlhm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reading_channel;
  logic [2:0] reading_status;
  logic       summary_valid;
  logic [8:0] batch_total;
  logic [8:0] blocking_total;
  logic [6:0] batch_score;
  logic [1:0] batch_band;
  logic [1:0] disposition;
  logic [7:0] worst_channel;
  logic [2:0] worst_status;
  logic [9:0] availability_tenths;
  logic [9:0] degradation_tenths;

  modport source (
    output valid, reading_channel, reading_status, summary_valid, batch_total,
           blocking_total, batch_score, batch_band, disposition,
           worst_channel, worst_status, availability_tenths,
           degradation_tenths,
    input  ready
  );

  modport sink (
    input  valid, reading_channel, reading_status, summary_valid, batch_total,
           blocking_total, batch_score, batch_band, disposition,
           worst_channel, worst_status, availability_tenths,
           degradation_tenths,
    output ready
  );
endinterface

/* src/tlhm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_front
// accepts readings and classifies each one into its status code
// ----------------------------------------------------------------------------
module tlhm_front import tlhm_pkg::*; (
  tlhm_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output item_t   q_item
);

  logic    cfg_ok;
  status_t status;

  assign cfg_ok = (in_ch.crit_low <= in_ch.warn_low) &&
                  (in_ch.warn_low <= in_ch.warn_high) &&
                  (in_ch.warn_high <= in_ch.crit_high) &&
                  !in_ch.aging_limit[31] &&
                  (in_ch.aging_limit <= in_ch.stale_limit);

  always_comb begin
    priority if (!cfg_ok) begin
      status = ST_CONFIG;
    end else if (!in_ch.value_present) begin
      status = ST_MISSING;
    end else if (!in_ch.age_present || in_ch.sample_age[31]) begin
      status = ST_BADTIME;
    end else if (in_ch.sample_age > in_ch.stale_limit) begin
      status = ST_STALE;
    end else if (in_ch.sample_value < in_ch.crit_low ||
                 in_ch.sample_value > in_ch.crit_high) begin
      status = ST_CRITICAL;
    end else if (in_ch.sample_value < in_ch.warn_low ||
                 in_ch.sample_value > in_ch.warn_high) begin
      status = ST_WARNING;
    end else if (in_ch.sample_age > in_ch.aging_limit) begin
      status = ST_AGING;
    end else begin
      status = ST_NOMINAL;
    end
  end

  assign in_ch.ready       = !q_full;
  assign q_push            = in_ch.valid && !q_full;
  assign q_item.channel    = in_ch.channel_id;
  assign q_item.status     = status;
  assign q_item.batch_last = in_ch.batch_end;

endmodule

/* src/tlhm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_queue
// short first-in first-out queue of classified words
// ----------------------------------------------------------------------------
module tlhm_queue import tlhm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  not_empty
);

  item_t           slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full      = (fill == (QA_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/tlhm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhm_back
// batch counters, held priority channel, summary math and result register
// ----------------------------------------------------------------------------
module tlhm_back import tlhm_pkg::*; #(
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  tlhm_out_if.source  out_ch
);

  localparam int CW     = $clog2(MAX_READINGS + 1);
  localparam int DW     = CW + TENTHS_W;
  localparam int STEP_W = $clog2(QUOT_W);

  function automatic logic [CLIP_W-1:0] clip(input logic [CW-1:0] c);
    logic [31:0] cx;
    cx = 32'(c);
    return (cx > 32'((1 << CLIP_W) - 1)) ? {CLIP_W{1'b1}} : cx[CLIP_W-1:0];
  endfunction

  back_state_t       state;
  back_state_t       state_next;

  logic [CW-1:0]     counts [8];
  logic [CW-1:0]     rd_count;
  logic [CW-1:0]     count_inc;
  logic [7:0]        held_channel;
  status_t           held_status;
  logic [2:0]        held_rank;
  logic              rank_seen;
  logic [2:0]        item_rank;
  logic              replace;
  logic              closing;

  logic [7:0]        pend_channel;
  status_t           pend_status;

  logic [CW-1:0]     unavail_sum;
  logic [CW-1:0]     blocking_sum;
  logic [PEN_W-1:0]  penalty;
  logic [6:0]        score;
  band_t             band;
  disp_t             disp;

  logic [CW-1:0]     unavail_r;
  logic [CW-1:0]     blocking_r;
  logic [6:0]        score_r;
  band_t             band_r;
  disp_t             disp_r;

  logic [CW-1:0]     avail;
  logic [CW-1:0]     degr;
  logic [DW-1:0]     rem_a;
  logic [DW-1:0]     rem_b;
  logic [DW-1:0]     dsh;
  logic [QUOT_W-1:0] quo_a;
  logic [QUOT_W-1:0] quo_b;
  logic [STEP_W-1:0] step;
  logic              ge_a;
  logic              ge_b;

  logic              out_free;
  logic              take;
  logic              load_item;
  logic              load_sum;

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign count_inc = rd_count + 1'b1;
  assign item_rank = rank_of(q_item.status);
  assign replace   = !rank_seen || (item_rank > held_rank);
  assign closing   = q_item.batch_last || (count_inc == CW'(MAX_READINGS));

  // summary terms from the finished counts
  assign unavail_sum  = counts[ST_STALE] + counts[ST_MISSING] +
                        counts[ST_BADTIME] + counts[ST_CONFIG];
  assign blocking_sum = unavail_sum + counts[ST_CRITICAL];
  assign penalty = PEN_W'(W_WARN * clip(counts[ST_WARNING])) +
                   PEN_W'(W_AGING * clip(counts[ST_AGING])) +
                   PEN_W'(W_CRIT * clip(counts[ST_CRITICAL])) +
                   PEN_W'(W_STALE * clip(counts[ST_STALE])) +
                   PEN_W'(W_MISSING * clip(counts[ST_MISSING])) +
                   PEN_W'(W_BADTIME * clip(counts[ST_BADTIME])) +
                   PEN_W'(W_CONFIG * clip(counts[ST_CONFIG]));
  assign score = (penalty >= PEN_W'(SCORE_FULL)) ? 7'd0
               : 7'(PEN_W'(SCORE_FULL) - penalty);

  always_comb begin
    priority if (score >= 7'(BAND_GREEN_MIN)) begin
      band = BAND_GREEN;
    end else if (score >= 7'(BAND_AMBER_MIN)) begin
      band = BAND_AMBER;
    end else begin
      band = BAND_RED;
    end
  end

  always_comb begin
    priority if (blocking_sum != '0) begin
      disp = DISP_HOLD;
    end else if (counts[ST_WARNING] != '0 || counts[ST_AGING] != '0) begin
      disp = DISP_MONITOR;
    end else begin
      disp = DISP_GO;
    end
  end

  assign avail = (rd_count > unavail_r) ? rd_count - unavail_r : '0;
  assign degr  = (rd_count > counts[ST_NOMINAL]) ? rd_count - counts[ST_NOMINAL] : '0;
  assign ge_a  = (rem_a >= dsh);
  assign ge_b  = (rem_b >= dsh);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (take && closing) begin
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: state_next = BK_PREP;
      BK_PREP: state_next = BK_DIV;
      BK_DIV: begin
        if (step == STEP_W'(QUOT_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    take      = 1'b0;
    load_item = 1'b0;
    load_sum  = 1'b0;
    unique case (state)
      BK_RUN: begin
        take      = q_valid && out_free;
        load_item = take && !closing;
      end
      BK_DONE: load_sum = out_free;
      default: ;
    endcase
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_RUN;
      rd_count     <= '0;
      held_channel <= '0;
      held_status  <= ST_NOMINAL;
      held_rank    <= '0;
      rank_seen    <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (load_item || load_sum) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (take) begin
        rd_count <= count_inc;
        for (int i = 0; i < 8; i++) begin
          if (q_item.status == status_t'(i)) begin
            counts[i] <= counts[i] + 1'b1;
          end
        end
        if (replace) begin
          rank_seen    <= 1'b1;
          held_rank    <= item_rank;
          held_channel <= q_item.channel;
          held_status  <= q_item.status;
        end
      end
      if (load_sum) begin
        rd_count     <= '0;
        held_channel <= '0;
        held_status  <= ST_NOMINAL;
        held_rank    <= '0;
        rank_seen    <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          counts[i] <= '0;
        end
      end
    end
  end

  // summary datapath and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      pend_channel <= q_item.channel;
      pend_status  <= q_item.status;
    end
    if (state == BK_LOAD) begin
      unavail_r  <= unavail_sum;
      blocking_r <= blocking_sum;
      score_r    <= score;
      band_r     <= band;
      disp_r     <= disp;
    end
    if (state == BK_PREP) begin
      rem_a <= DW'(avail) * DW'(TENTHS_SCALE) + DW'(rd_count);
      rem_b <= DW'(degr) * DW'(TENTHS_SCALE) + DW'(rd_count);
      dsh   <= DW'(rd_count) << QUOT_W;
      step  <= '0;
      quo_a <= '0;
      quo_b <= '0;
    end
    if (state == BK_DIV) begin
      rem_a <= ge_a ? rem_a - dsh : rem_a;
      rem_b <= ge_b ? rem_b - dsh : rem_b;
      quo_a <= {quo_a[QUOT_W-2:0], ge_a};
      quo_b <= {quo_b[QUOT_W-2:0], ge_b};
      dsh   <= dsh >> 1;
      step  <= step + 1'b1;
    end
    if (load_item) begin
      out_ch.reading_channel     <= q_item.channel;
      out_ch.reading_status      <= q_item.status;
      out_ch.summary_valid       <= 1'b0;
      out_ch.batch_total         <= '0;
      out_ch.blocking_total      <= '0;
      out_ch.batch_score         <= '0;
      out_ch.batch_band          <= '0;
      out_ch.disposition         <= '0;
      out_ch.worst_channel       <= '0;
      out_ch.worst_status        <= '0;
      out_ch.availability_tenths <= '0;
      out_ch.degradation_tenths  <= '0;
    end
    if (load_sum) begin
      out_ch.reading_channel     <= pend_channel;
      out_ch.reading_status      <= pend_status;
      out_ch.summary_valid       <= 1'b1;
      out_ch.batch_total         <= 9'(rd_count);
      out_ch.blocking_total      <= 9'(blocking_r);
      out_ch.batch_score         <= score_r;
      out_ch.batch_band          <= band_r;
      out_ch.disposition         <= disp_r;
      out_ch.worst_channel       <= held_channel;
      out_ch.worst_status        <= held_status;
      out_ch.availability_tenths <= quo_a;
      out_ch.degradation_tenths  <= quo_b;
    end
  end

endmodule

/* src/telemetry_limit_health_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_limit_health_monitor
// classifies telemetry readings against limits and reports batch health
// ----------------------------------------------------------------------------
//
//   port     dir  handshake     word
//   -------  ---  ------------  ----------------------------------------------
//   in_ch    in   valid/ready   one reading: value, limits, age, batch end
//   out_ch   out  valid/ready   one result per reading, summary on batch close
//
// a reading that does not close its batch is taken by the back end at once,
// so the block sustains one reading per cycle while the result side keeps up
// and no batch is closing. a closing reading passes through counter update,
// summary terms, divider setup and 10 steps of the restoring divider that
// forms both tenths figures over a shared divisor, then the result load; the
// front keeps filling the 4-word queue meanwhile. reset is synchronous and
// clears counters, held channel, queue and result valid. a stalled result holds
// in the output register while the next reading still enters the queue.
// ----------------------------------------------------------------------------
module telemetry_limit_health_monitor import tlhm_pkg::*; #(
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tlhm_in_if.sink    in_ch,
  tlhm_out_if.source out_ch
);

  // front to queue
  logic  q_push;
  item_t q_push_item;
  logic  q_full;

  // queue to back
  logic  q_pop;
  item_t q_pop_item;
  logic  q_valid;

  // classification of each incoming reading
  tlhm_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  // decouples acceptance from the summary math
  tlhm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .not_empty (q_valid)
  );

  // counting, priority tracking, summary and result register
  tlhm_back #(
    .MAX_READINGS (MAX_READINGS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_pop_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // band must agree with the score it came from
  a_band_green: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.summary_valid |->
      ((out_ch.batch_score >= 7'(BAND_GREEN_MIN)) ==
       (out_ch.batch_band == BAND_GREEN)))
    else $error("health band disagrees with health score");

  // go means nothing blocking in the batch
  a_go_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.summary_valid && (out_ch.disposition == DISP_GO) |->
      (out_ch.blocking_total == '0))
    else $error("go disposition with blocking readings");

  // an all-nominal batch is perfect
  a_nominal_batch: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.summary_valid && (out_ch.worst_status == ST_NOMINAL) |->
      (out_ch.degradation_tenths == '0) && (out_ch.batch_score == 7'(SCORE_FULL)))
    else $error("nominal batch reports degradation");

  // summary fields stay clear on ordinary results
  a_no_summary: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.summary_valid |->
      (out_ch.batch_total == '0) && (out_ch.batch_score == '0) &&
      (out_ch.availability_tenths == '0) && (out_ch.worst_channel == '0))
    else $error("summary fields set outside batch close");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the telemetry limit health monitor
// ----------------------------------------------------------------------------
// a directed table covers every status, the limit and age boundaries, the
// field extremes and priority holding; it is followed by random batches of
// mostly well-formed readings with some noise and two overflowing batches.
// an in-bench health predictor forms the expected word for each accepted
// reading and results are checked in order, field by field. both sides idle
// in random bursts, except in the closing stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import tlhm_pkg::*;

  localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_TAIL   = 300;    // last readings sent with no idling
  localparam int DRAIN_WAIT   = 40;
  localparam longint INT_MAX  = 64'sd2147483647;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [7:0]         chan;
    logic signed [31:0] value;
    logic               value_ok;
    logic signed [31:0] warn_lo;
    logic signed [31:0] warn_hi;
    logic signed [31:0] crit_lo;
    logic signed [31:0] crit_hi;
    logic signed [31:0] age;
    logic               age_ok;
    logic signed [31:0] aging_lim;
    logic signed [31:0] stale_lim;
    logic               last;
  } reading_t;

  typedef struct {
    logic [7:0] chan;
    status_t    status;
    logic       summ;
    logic [8:0] total;
    logic [8:0] blocking;
    logic [6:0] score;
    band_t      band;
    disp_t      disp;
    logic [7:0] prio_chan;
    status_t    prio_status;
    logic [9:0] avail;
    logic [9:0] degr;
  } health_result_t;

  typedef struct {
    reading_t       rd;
    bit             typed;
    health_result_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  tlhm_in_if  in_ch ();
  tlhm_out_if out_ch ();

  telemetry_limit_health_monitor u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // expected words, oldest first
  health_result_t pending_results[$];
  plan_row_t      directed_plan[$];

  int  failures;
  int  idle_cycles;
  bit  src_idle_on;
  bit  sink_idle_on;

  // batch state of the predictor
  int unsigned tally[8];
  int unsigned batch_len;
  logic [7:0]  lead_chan;
  status_t     lead_status;
  int unsigned lead_rank;
  bit          lead_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // first failing check in fixed order wins
  function automatic status_t classify_reading(reading_t r);
    if (!(r.crit_lo <= r.warn_lo && r.warn_lo <= r.warn_hi && r.warn_hi <= r.crit_hi &&
          r.aging_lim >= 0 && r.aging_lim <= r.stale_lim))
      return ST_CONFIG;
    if (!r.value_ok)
      return ST_MISSING;
    if (!r.age_ok || r.age < 0)
      return ST_BADTIME;
    if (r.age > r.stale_lim)
      return ST_STALE;
    if (r.value < r.crit_lo || r.value > r.crit_hi)
      return ST_CRITICAL;
    if (r.value < r.warn_lo || r.value > r.warn_hi)
      return ST_WARNING;
    if (r.age > r.aging_lim)
      return ST_AGING;
    return ST_NOMINAL;
  endfunction

  // priority for the held channel, not the status code order
  function automatic int unsigned severity_rank(status_t s);
    case (s)
      ST_CONFIG:   return 7;
      ST_MISSING:  return 6;
      ST_CRITICAL: return 5;
      ST_STALE:    return 4;
      ST_BADTIME:  return 3;
      ST_WARNING:  return 2;
      ST_AGING:    return 1;
      default:     return 0;
    endcase
  endfunction

  // per-thousand share, rounded half up
  function automatic int unsigned tenths_of(int unsigned part, int unsigned whole);
    return (TENTHS_SCALE * part + whole) / (2 * whole);
  endfunction

  task automatic clear_batch();
    foreach (tally[k]) tally[k] = 0;
    batch_len   = 0;
    lead_chan   = '0;
    lead_status = ST_NOMINAL;
    lead_rank   = 0;
    lead_seen   = 1'b0;
  endtask

  task automatic predict_health(reading_t r, output health_result_t res);
    status_t     st;
    int unsigned rk, unavail, blocking, penalty, score, avail, degr;
    st = classify_reading(r);
    rk = severity_rank(st);
    tally[st]++;
    batch_len++;
    if (!lead_seen || rk > lead_rank) begin
      lead_seen   = 1'b1;
      lead_rank   = rk;
      lead_chan   = r.chan;
      lead_status = st;
    end
    res.chan        = r.chan;
    res.status      = st;
    res.summ        = 1'b0;
    res.total       = '0;
    res.blocking    = '0;
    res.score       = '0;
    res.band        = BAND_GREEN;
    res.disp        = DISP_GO;
    res.prio_chan   = '0;
    res.prio_status = ST_NOMINAL;
    res.avail       = '0;
    res.degr        = '0;
    // a full batch closes as if batch end were set
    if (r.last || batch_len >= MAX_READINGS_DEF) begin
      unavail  = tally[ST_STALE] + tally[ST_MISSING] + tally[ST_BADTIME] + tally[ST_CONFIG];
      blocking = unavail + tally[ST_CRITICAL];
      penalty  = W_WARN * tally[ST_WARNING] + W_AGING * tally[ST_AGING] +
                 W_CRIT * tally[ST_CRITICAL] + W_STALE * tally[ST_STALE] +
                 W_MISSING * tally[ST_MISSING] + W_BADTIME * tally[ST_BADTIME] +
                 W_CONFIG * tally[ST_CONFIG];
      score    = (penalty >= SCORE_FULL) ? 0 : SCORE_FULL - penalty;
      avail    = (batch_len > unavail) ? batch_len - unavail : 0;
      degr     = (batch_len > tally[ST_NOMINAL]) ? batch_len - tally[ST_NOMINAL] : 0;
      res.summ        = 1'b1;
      res.total       = batch_len[8:0];
      res.blocking    = blocking[8:0];
      res.score       = score[6:0];
      res.band        = (score >= BAND_GREEN_MIN) ? BAND_GREEN :
                        (score >= BAND_AMBER_MIN) ? BAND_AMBER : BAND_RED;
      res.disp        = (blocking > 0) ? DISP_HOLD :
                        (tally[ST_WARNING] > 0 || tally[ST_AGING] > 0) ? DISP_MONITOR : DISP_GO;
      res.prio_chan   = lead_chan;
      res.prio_status = lead_status;
      res.avail       = 10'(tenths_of(avail, batch_len));
      res.degr        = 10'(tenths_of(degr, batch_len));
      clear_batch();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // quiet reading: comfortably inside every limit, young, present
  function automatic reading_t base_reading(logic [7:0] chan, logic last);
    reading_t r;
    r.chan      = chan;
    r.value     = 0;
    r.value_ok  = 1'b1;
    r.warn_lo   = -50;
    r.warn_hi   = 50;
    r.crit_lo   = -100;
    r.crit_hi   = 100;
    r.age       = 10;
    r.age_ok    = 1'b1;
    r.aging_lim = 100;
    r.stale_lim = 1000;
    r.last      = last;
    return r;
  endfunction

  // summary of a batch of one reading
  function automatic health_result_t single_close(logic [7:0] chan, status_t st,
                                                  int blocking, int score, band_t band,
                                                  disp_t disp, int avail, int degr);
    health_result_t h;
    h.chan        = chan;
    h.status      = st;
    h.summ        = 1'b1;
    h.total       = 9'd1;
    h.blocking    = 9'(blocking);
    h.score       = 7'(score);
    h.band        = band;
    h.disp        = disp;
    h.prio_chan   = chan;
    h.prio_status = st;
    h.avail       = 10'(avail);
    h.degr        = 10'(degr);
    return h;
  endfunction

  task automatic add_row(reading_t r, bit typed, health_result_t want);
    plan_row_t row;
    row.rd    = r;
    row.typed = typed;
    row.want  = want;
    directed_plan.insert(directed_plan.size(), row);
  endtask

  function automatic int pick_between(longint lo, longint hi);
    longint unsigned w;
    w = hi - lo + 1;
    return int'(lo + longint'({$urandom, $urandom} % w));
  endfunction

  function automatic reading_t random_reading(logic last);
    reading_t r;
    int       lim[4];
    int       spread, tmp, al, sl;
    longint   wide_sl;
    r.chan = 8'($urandom);
    r.last = last;
    // noise: every field arbitrary, batch end included
    if ($urandom_range(9) == 0) begin
      r.value     = $urandom;
      r.value_ok  = 1'($urandom);
      r.warn_lo   = $urandom;
      r.warn_hi   = $urandom;
      r.crit_lo   = $urandom;
      r.crit_hi   = $urandom;
      r.age       = $urandom;
      r.age_ok    = 1'($urandom);
      r.aging_lim = $urandom;
      r.stale_lim = $urandom;
      r.last      = 1'($urandom);
      return r;
    end
    case ($urandom_range(3))
      0:       spread = 100;
      1:       spread = 10000;
      2:       spread = 1000000;
      default: spread = 0;
    endcase
    foreach (lim[k]) lim[k] = (spread == 0) ? int'($urandom) : pick_between(-spread, spread);
    // ordered limits give a valid window
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3 - k; j++)
        if (lim[j] > lim[j+1]) begin
          tmp      = lim[j];
          lim[j]   = lim[j+1];
          lim[j+1] = tmp;
        end
    r.crit_lo = lim[0];
    r.warn_lo = lim[1];
    r.warn_hi = lim[2];
    r.crit_hi = lim[3];
    case ($urandom_range(5))
      0, 1:    r.value = pick_between(lim[1], lim[2]);
      2:       r.value = pick_between(lim[0], lim[3]);
      3:       r.value = pick_between(longint'(lim[0]) - 50, longint'(lim[3]) + 50);
      4:       r.value = lim[$urandom_range(3)] + int'($urandom_range(2)) - 1;
      default: r.value = $urandom;
    endcase
    al      = ($urandom_range(7) == 0) ? int'($urandom_range(32'h7fff_ffff)) :
                                         int'($urandom_range(5000));
    wide_sl = longint'(al) + $urandom_range(5000);
    sl      = (wide_sl > INT_MAX) ? int'(INT_MAX) : int'(wide_sl);
    r.aging_lim = al;
    r.stale_lim = sl;
    case ($urandom_range(6))
      2:       r.age = pick_between(al, sl);
      3:       r.age = pick_between(sl, longint'(sl) + 100);
      4:       r.age = -int'($urandom_range(1000, 1));
      5:       r.age = ($urandom_range(1) ? al : sl) + int'($urandom_range(1));
      default: r.age = pick_between(0, al);
    endcase
    r.value_ok = ($urandom_range(19) != 0);
    r.age_ok   = ($urandom_range(19) != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reading side: entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_reading(reading_t r, bit typed, health_result_t want);
    health_result_t res;
    int             gap;
    if (src_idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(6, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.channel_id    <= r.chan;
    in_ch.sample_value  <= r.value;
    in_ch.value_present <= r.value_ok;
    in_ch.warn_low      <= r.warn_lo;
    in_ch.warn_high     <= r.warn_hi;
    in_ch.crit_low      <= r.crit_lo;
    in_ch.crit_high     <= r.crit_hi;
    in_ch.sample_age    <= r.age;
    in_ch.age_present   <= r.age_ok;
    in_ch.aging_limit   <= r.aging_lim;
    in_ch.stale_limit   <= r.stale_lim;
    in_ch.batch_end     <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    // predictor always runs so its batch state follows the block
    predict_health(r, res);
    pending_results.insert(pending_results.size(), typed ? want : res);
    @(negedge clk);
  endtask

  // hold the reading side until every expected word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  int stall_left;

  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(3) == 0) begin
        stall_left   = $urandom_range(5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic compare_result(health_result_t exp_r, health_result_t act_r);
    bit bad;
    bad = (exp_r.chan !== act_r.chan) || (exp_r.status !== act_r.status) ||
          (exp_r.summ !== act_r.summ) || (exp_r.total !== act_r.total) ||
          (exp_r.blocking !== act_r.blocking) || (exp_r.score !== act_r.score) ||
          (exp_r.band !== act_r.band) || (exp_r.disp !== act_r.disp) ||
          (exp_r.prio_chan !== act_r.prio_chan) ||
          (exp_r.prio_status !== act_r.prio_status) ||
          (exp_r.avail !== act_r.avail) || (exp_r.degr !== act_r.degr);
    if (bad) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch at %0t", $realtime);
        $display("  expected %p", exp_r);
        $display("  actual   %p", act_r);
      end
    end
  endtask

  always @(posedge clk) begin
    health_result_t act_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      act_r.chan        = out_ch.reading_channel;
      act_r.status      = status_t'(out_ch.reading_status);
      act_r.summ        = out_ch.summary_valid;
      act_r.total       = out_ch.batch_total;
      act_r.blocking    = out_ch.blocking_total;
      act_r.score       = out_ch.batch_score;
      act_r.band        = band_t'(out_ch.batch_band);
      act_r.disp        = disp_t'(out_ch.disposition);
      act_r.prio_chan   = out_ch.worst_channel;
      act_r.prio_status = status_t'(out_ch.worst_status);
      act_r.avail       = out_ch.availability_tenths;
      act_r.degr        = out_ch.degradation_tenths;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result word with no reading pending at %0t: %p", $realtime, act_r);
      end else begin
        compare_result(pending_results.pop_front(), act_r);
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reading_t       r;
    health_result_t none;
    int             sent, batch_no, len;
    bit             overflow;

    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.channel_id    = '0;
    in_ch.sample_value  = '0;
    in_ch.value_present = 1'b0;
    in_ch.warn_low      = '0;
    in_ch.warn_high     = '0;
    in_ch.crit_low      = '0;
    in_ch.crit_high     = '0;
    in_ch.sample_age    = '0;
    in_ch.age_present   = 1'b0;
    in_ch.aging_limit   = '0;
    in_ch.stale_limit   = '0;
    in_ch.batch_end     = 1'b0;
    src_idle_on         = 1'b1;
    sink_idle_on        = 1'b1;
    clear_batch();

    // single-reading batches: summary read straight off the status
    r = base_reading(8'd0, 1'b1);
    add_row(r, 1, single_close(8'd0, ST_NOMINAL, 0, 100, BAND_GREEN, DISP_GO, 1000, 0));
    r = base_reading(8'd1, 1'b1); r.crit_lo = -40;     // limits out of order
    add_row(r, 1, single_close(8'd1, ST_CONFIG, 1, 75, BAND_AMBER, DISP_HOLD, 0, 1000));
    r = base_reading(8'd2, 1'b1); r.value_ok = 1'b0;
    add_row(r, 1, single_close(8'd2, ST_MISSING, 1, 75, BAND_AMBER, DISP_HOLD, 0, 1000));
    r = base_reading(8'd3, 1'b1); r.age_ok = 1'b0;
    add_row(r, 1, single_close(8'd3, ST_BADTIME, 1, 80, BAND_AMBER, DISP_HOLD, 0, 1000));
    r = base_reading(8'd4, 1'b1); r.age = -1;          // negative age
    add_row(r, 1, single_close(8'd4, ST_BADTIME, 1, 80, BAND_AMBER, DISP_HOLD, 0, 1000));
    r = base_reading(8'd5, 1'b1); r.age = 1001;
    add_row(r, 1, single_close(8'd5, ST_STALE, 1, 80, BAND_AMBER, DISP_HOLD, 0, 1000));
    r = base_reading(8'd6, 1'b1); r.value = 101;
    add_row(r, 1, single_close(8'd6, ST_CRITICAL, 1, 75, BAND_AMBER, DISP_HOLD, 1000, 1000));
    r = base_reading(8'd7, 1'b1); r.value = -51;
    add_row(r, 1, single_close(8'd7, ST_WARNING, 0, 92, BAND_GREEN, DISP_MONITOR, 1000, 1000));
    r = base_reading(8'd8, 1'b1); r.age = 101;
    add_row(r, 1, single_close(8'd8, ST_AGING, 0, 95, BAND_GREEN, DISP_MONITOR, 1000, 1000));

    // field extremes, everything equal, still nominal
    r = base_reading(8'd255, 1'b1);
    r.value = S32_MIN; r.warn_lo = S32_MIN; r.warn_hi = S32_MIN;
    r.crit_lo = S32_MIN; r.crit_hi = S32_MIN;
    r.age = 0; r.aging_lim = 0; r.stale_lim = 0;
    add_row(r, 1, single_close(8'd255, ST_NOMINAL, 0, 100, BAND_GREEN, DISP_GO, 1000, 0));
    r = base_reading(8'd128, 1'b1);
    r.value = S32_MAX; r.warn_lo = S32_MAX; r.warn_hi = S32_MAX;
    r.crit_lo = S32_MAX; r.crit_hi = S32_MAX;
    r.age = S32_MAX; r.aging_lim = S32_MAX; r.stale_lim = S32_MAX;
    add_row(r, 1, single_close(8'd128, ST_NOMINAL, 0, 100, BAND_GREEN, DISP_GO, 1000, 0));

    // mixed batch: age limit checks, boundaries, stale ahead of critical
    r = base_reading(8'd10, 1'b0); r.aging_lim = -1;        add_row(r, 0, none);
    r = base_reading(8'd11, 1'b0); r.aging_lim = 2000;      add_row(r, 0, none);
    r = base_reading(8'd12, 1'b0); r.value = 100;           add_row(r, 0, none);
    r = base_reading(8'd13, 1'b0); r.age = 1000;            add_row(r, 0, none);
    r = base_reading(8'd14, 1'b0); r.value = -100;          add_row(r, 0, none);
    r = base_reading(8'd15, 1'b0); r.age = 100;             add_row(r, 0, none);
    r = base_reading(8'd16, 1'b0); r.value = S32_MAX;       add_row(r, 0, none);
    r = base_reading(8'd17, 1'b1); r.value = S32_MIN; r.age = S32_MAX;
    add_row(r, 0, none);

    // priority: first of equal rank is kept, lower rank never replaces
    r = base_reading(8'd20, 1'b0);                          add_row(r, 0, none);
    r = base_reading(8'd21, 1'b0);                          add_row(r, 0, none);
    r = base_reading(8'd22, 1'b0); r.value = 60;            add_row(r, 0, none);
    r = base_reading(8'd23, 1'b1); r.age = 500;             add_row(r, 0, none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      send_reading(directed_plan[i].rd, directed_plan[i].typed, directed_plan[i].want);
    wait_drained();

    // random batches; two of them run past the batch size limit
    sent     = 0;
    batch_no = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle_on  = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(3) != 0);
      sink_idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(3) != 0);
      overflow     = (batch_no == 8 || batch_no == 90);
      if (overflow)
        len = MAX_READINGS_DEF + 20;
      else if ($urandom_range(9) == 0)
        len = $urandom_range(60, 13);
      else
        len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        r = random_reading(!overflow && k == len - 1);
        // an overflowing batch must reach the size limit
        if (overflow)
          r.last = 1'b0;
        send_reading(r, 0, none);
        sent++;
      end
      if (batch_no == 40)
        wait_drained();
      batch_no++;
    end

    // end of stimulus: let everything come back, then a little longer
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
